>>> design/assert_macros.svh
// Assertion helpers shared by the RTL; every use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_AT(lbl, !(cond), msg)

`endif

>>> design/tpl_pkg.sv
// ----------------------------------------------------------------------------
// tpl_pkg
// Widths, register codes and helper functions of the triangle point locator.
// ----------------------------------------------------------------------------
package tpl_pkg;

  localparam int COORD_BITS       = 24;
  localparam int WEIGHT_FRAC_BITS = 29;
  localparam int W_BITS           = 32;
  localparam int DIFF_W           = COORD_BITS + 1;
  localparam int PROD_W           = 2 * DIFF_W;
  localparam int CROSS_W          = PROD_W + 1;
  localparam int SUM_W            = CROSS_W + 2;
  localparam int MAG_W            = SUM_W;
  localparam int LOW_W            = W_BITS - WEIGHT_FRAC_BITS;
  localparam int BITS_PER_ST      = 2;
  localparam int DIV_ST           = W_BITS / BITS_PER_ST;
  localparam int CLS_W            = W_BITS + 2;
  localparam int TOL_W            = 16;
  localparam int ET_W             = 12;
  localparam int ADDR_W           = 3;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(5);
  localparam logic [ET_W-1:0]  ET_RESET  = ET_W'(660);

  // register select bit of the APB address
  localparam logic REG_TOL  = 1'b0;
  localparam logic REG_EDGE = 1'b1;

  localparam logic [1:0] IDX_NONE = 2'd3;

  localparam logic signed [CLS_W-1:0] ONE = CLS_W'(1) <<< WEIGHT_FRAC_BITS;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic             q;
  } dstep_t;

  typedef struct packed {
    logic [MAG_W-1:0]  rem;
    logic [W_BITS-1:0] low;
    logic [W_BITS-1:0] quo;
    logic              neg;
    logic              ovf;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]      lanes;
    logic [MAG_W-1:0] dsor;
    logic             zero;
  } div_t;

  // One restoring division step; rem stays below dsor.
  function automatic dstep_t div_step(input logic [MAG_W-1:0] rem, input logic bit_in,
                                      input logic [MAG_W-1:0] dsor);
    logic [MAG_W:0] sh;
    logic [MAG_W:0] diff;
    dstep_t         r;
    sh   = {rem, bit_in};
    diff = sh - {1'b0, dsor};
    if (sh >= {1'b0, dsor}) begin
      r.rem = diff[MAG_W-1:0];
      r.q   = 1'b1;
    end else begin
      r.rem = sh[MAG_W-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

  // Apply the sign and saturate to a signed 32-bit weight.
  function automatic logic [W_BITS-1:0] sat_weight(input logic [W_BITS-1:0] quo,
                                                   input logic neg, input logic ovf);
    logic [W_BITS-1:0] r;
    if (neg) begin
      if (ovf || quo > {1'b1, {(W_BITS-1){1'b0}}}) r = {1'b1, {(W_BITS-1){1'b0}}};
      else r = -quo;
    end else begin
      if (ovf || quo[W_BITS-1]) r = {1'b0, {(W_BITS-1){1'b1}}};
      else r = quo;
    end
    return r;
  endfunction

endpackage

>>> design/triangle_point_locate.sv
// ----------------------------------------------------------------------------
// triangle_point_locate
// Barycentric point-in-triangle test. Each request carries three corners and
// a query point (signed 24-bit fixed point); the response gives the three
// weights in signed Q2.29 (saturated), a found flag, and the corner or edge
// the point sits on within the programmed tolerance. The block is a
// 24-stage pipeline: one request enters per cycle when the output side
// does not stall. The depth is set by the three parallel restoring
// dividers, which resolve two quotient bits per stage over sixteen stages.
// Empty stages collapse, so input is still taken while a finished
// response waits. Registers (APB, 32-bit): tolerance at 0x0 (reset 5),
// edge table at 0x4 (reset 0x294, edges 0-1, 1-2, 2-0). Write them only
// while no request is in flight.
// ----------------------------------------------------------------------------
module triangle_point_locate
  import tpl_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // request
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] corner0_x_i,
  input  logic signed [COORD_BITS-1:0] corner0_y_i,
  input  logic signed [COORD_BITS-1:0] corner1_x_i,
  input  logic signed [COORD_BITS-1:0] corner1_y_i,
  input  logic signed [COORD_BITS-1:0] corner2_x_i,
  input  logic signed [COORD_BITS-1:0] corner2_y_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  // response
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [1:0]                   on_corner_o,
  output logic [1:0]                   on_edge_o,
  output logic signed [W_BITS-1:0]     weight_a_o,
  output logic signed [W_BITS-1:0]     weight_b_o,
  output logic signed [W_BITS-1:0]     weight_c_o
);

  // Stage map: 0 diffs, 1 products, 2 cross, 3 sum and magnitudes,
  // 4 divisor, 5 divider setup, 6.. divider, then saturate, then classify.
  localparam int ST_DIV0 = 5;
  localparam int ST_SAT  = ST_DIV0 + DIV_ST + 1;
  localparam int NST     = ST_SAT + 2;

  // -------------------------------------------------------------- registers
  logic [TOL_W-1:0] tol_q;
  logic [ET_W-1:0]  et_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      et_q  <= ET_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TOL) tol_q <= pwdata[TOL_W-1:0];
      else                     et_q  <= pwdata[ET_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EDGE) ? {{(32-ET_W){1'b0}}, et_q}
                                         : {{(32-TOL_W){1'b0}}, tol_q};

  // -------------------------------------------------------- valid and stall
  // A stage loads when it is empty or the stage after it moves on.
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NST-1];

  // ------------------------------------------------- stage 0: differences
  logic signed [DIFF_W-1:0] dx_q [3];
  logic signed [DIFF_W-1:0] dy_q [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q[0] <= DIFF_W'(corner0_x_i) - DIFF_W'(query_x_i);
      dy_q[0] <= DIFF_W'(corner0_y_i) - DIFF_W'(query_y_i);
      dx_q[1] <= DIFF_W'(corner1_x_i) - DIFF_W'(query_x_i);
      dy_q[1] <= DIFF_W'(corner1_y_i) - DIFF_W'(query_y_i);
      dx_q[2] <= DIFF_W'(corner2_x_i) - DIFF_W'(query_x_i);
      dy_q[2] <= DIFF_W'(corner2_y_i) - DIFF_W'(query_y_i);
    end
  end

  // --------------------------------------------------- stage 1: products
  // Weight i uses the two other corners, i+1 and i+2 mod 3.
  logic signed [PROD_W-1:0] pa_q [3];
  logic signed [PROD_W-1:0] pb_q [3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        pa_q[i] <= dx_q[(i+1)%3] * dy_q[(i+2)%3];
        pb_q[i] <= dy_q[(i+1)%3] * dx_q[(i+2)%3];
      end
    end
  end

  // ------------------------------------------------ stage 2: cross products
  logic signed [CROSS_W-1:0] cr_q [3];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        cr_q[i] <= CROSS_W'(pa_q[i]) - CROSS_W'(pb_q[i]);
      end
    end
  end

  // ------------------------------------------ stage 3: sum and magnitudes
  logic signed [SUM_W-1:0] sum_q;
  logic [MAG_W-1:0]        crm3_q [3];
  logic [2:0]              crn3_q;
  logic signed [SUM_W-1:0] cr_ext [3];

  always_comb begin
    for (int i = 0; i < 3; i++) cr_ext[i] = SUM_W'(cr_q[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sum_q <= cr_ext[0] + cr_ext[1] + cr_ext[2];
      for (int i = 0; i < 3; i++) begin
        crm3_q[i] <= cr_ext[i][SUM_W-1] ? MAG_W'(-cr_ext[i]) : MAG_W'(cr_ext[i]);
        crn3_q[i] <= cr_ext[i][SUM_W-1];
      end
    end
  end

  // ----------------------------------------------------- stage 4: divisor
  logic [MAG_W-1:0] dsor4_q;
  logic             sneg4_q;
  logic             zero4_q;
  logic [MAG_W-1:0] crm4_q [3];
  logic [2:0]       crn4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dsor4_q <= sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
      sneg4_q <= sum_q[SUM_W-1];
      zero4_q <= (sum_q == '0);
      crm4_q  <= crm3_q;
      crn4_q  <= crn3_q;
    end
  end

  // --------------------------------------------------- divider pipeline
  // Dividend is |cross| << frac bits; its high part seeds the remainder and
  // the low 32 bits feed in one bit per step. A quotient of 2^32 or more is
  // flagged up front and saturates later.
  div_t div_q [DIV_ST+1];
  div_t div_init;

  always_comb begin
    div_init.dsor = dsor4_q;
    div_init.zero = zero4_q;
    for (int l = 0; l < 3; l++) begin
      div_init.lanes[l].rem = crm4_q[l] >> LOW_W;
      div_init.lanes[l].low = {crm4_q[l][LOW_W-1:0], {WEIGHT_FRAC_BITS{1'b0}}};
      div_init.lanes[l].quo = '0;
      div_init.lanes[l].neg = crn4_q[l] ^ sneg4_q;
      div_init.lanes[l].ovf = (MAG_W+LOW_W)'(crm4_q[l]) >= {dsor4_q, {LOW_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DIV0]) div_q[0] <= div_init;
  end

  for (genvar j = 0; j < DIV_ST; j++) begin : g_div
    div_t   nxt;
    dstep_t st;

    always_comb begin
      nxt = div_q[j];
      st  = '0;
      for (int l = 0; l < 3; l++) begin
        for (int b = 0; b < BITS_PER_ST; b++) begin
          st = div_step(nxt.lanes[l].rem, nxt.lanes[l].low[W_BITS-1], nxt.dsor);
          nxt.lanes[l].rem = st.rem;
          nxt.lanes[l].low = nxt.lanes[l].low << 1;
          nxt.lanes[l].quo = {nxt.lanes[l].quo[W_BITS-2:0], st.q};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_DIV0+1+j]) div_q[j+1] <= nxt;
    end
  end

  // --------------------------------------------------- saturate weights
  logic signed [W_BITS-1:0] w_q [3];
  logic                     zero_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_SAT]) begin
      zero_q <= div_q[DIV_ST].zero;
      for (int l = 0; l < 3; l++) begin
        w_q[l] <= div_q[DIV_ST].zero ? '0
                : sat_weight(div_q[DIV_ST].lanes[l].quo, div_q[DIV_ST].lanes[l].neg,
                             div_q[DIV_ST].lanes[l].ovf);
      end
    end
  end

  // ------------------------------------------------------ classification
  logic signed [CLS_W-1:0] wx   [4];
  logic signed [CLS_W-1:0] tolx;
  logic signed [CLS_W-1:0] dlt;
  logic [3:0]              nib;
  logic                    in_tri;
  logic [1:0]              corner;
  logic [1:0]              edge_idx;

  always_comb begin
    tolx = CLS_W'(tol_q);
    for (int i = 0; i < 3; i++) wx[i] = CLS_W'(w_q[i]);
    wx[3]  = '0;   // corner index 3 in the edge table reads as zero
    in_tri = !zero_q;
    for (int i = 0; i < 3; i++) begin
      if (!(wx[i] > -tolx && wx[i] < ONE + tolx)) in_tri = 1'b0;
    end
    corner   = IDX_NONE;
    edge_idx = IDX_NONE;
    dlt      = '0;
    nib      = '0;
    if (in_tri) begin
      for (int i = 0; i < 3; i++) begin
        dlt = wx[i] - ONE;
        if (corner == IDX_NONE && dlt > -tolx && dlt < tolx) corner = 2'(i);
      end
      for (int i = 0; i < 3; i++) begin
        nib = et_q[4*i +: 4];
        dlt = wx[nib[1:0]] + wx[nib[3:2]] - ONE;
        if (corner == IDX_NONE && edge_idx == IDX_NONE && dlt > -tolx && dlt < tolx) begin
          edge_idx = 2'(i);
        end
      end
    end
  end

  // ------------------------------------------------------ response register
  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      found_o     <= in_tri;
      on_corner_o <= corner;
      on_edge_o   <= edge_idx;
      weight_a_o  <= w_q[0];
      weight_b_o  <= w_q[1];
      weight_c_o  <= w_q[2];
    end
  end

  // ------------------------------------------------------------ assertions
`include "assert_macros.svh"

  `ASSERT_AT(a_corner_excl_edge, out_valid_o && on_corner_o != IDX_NONE |-> on_edge_o == IDX_NONE, "corner and edge both reported")
  `ASSERT_AT(a_miss_no_class, out_valid_o && !found_o |-> on_corner_o == IDX_NONE && on_edge_o == IDX_NONE, "class reported for a miss")
  `ASSERT_AT(a_accept_fills, in_valid_i && in_ready_o |=> v_q[0], "accepted request lost at entry")
  `ASSERT_NEVER(a_stall_blocks, out_valid_o && !out_ready_i && v_q == '1 && in_ready_o, "ready while pipeline is full and stalled")

endmodule
